FILE: design/bbr_pkg.sv
package bbr_pkg;

  localparam int RBW = 11;
  localparam int PLW = 4;
  localparam int ROWW = 13;
  localparam int RUNW = 8;
  localparam int CFG_IDXW = 3;
  localparam int CFG_DW = 13;

  localparam int DEF_MAX_ROW_BYTES = 1024;
  localparam int DEF_MAX_ROWS = 4096;
  localparam int DEF_MAX_PLANES = 8;

  localparam logic [CFG_IDXW-1:0] CFG_ROW_BYTES = 3'd0;
  localparam logic [CFG_IDXW-1:0] CFG_PLANE_COUNT = 3'd1;
  localparam logic [CFG_IDXW-1:0] CFG_IMAGE_ROWS = 3'd2;
  localparam logic [CFG_IDXW-1:0] CFG_COMPRESSED = 3'd3;
  localparam logic [CFG_IDXW-1:0] CFG_HAS_MASK = 3'd4;

  localparam logic [RBW-1:0] RST_ROW_BYTES = 11'd40;
  localparam logic [PLW-1:0] RST_PLANE_COUNT = 4'd5;
  localparam logic [ROWW-1:0] RST_IMAGE_ROWS = 13'd256;
  localparam logic RST_COMPRESSED = 1'b1;
  localparam logic RST_HAS_MASK = 1'b0;

  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_REPEAT = 2'd1;
  localparam logic [1:0] KIND_NOP = 2'd2;

  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_LITERAL = 2'd1;
  localparam logic [1:0] PHASE_REPEAT = 2'd2;

  typedef struct packed {
    logic [7:0] body;
    logic [1:0] kind;
    logic [RUNW-1:0] len;
  } entry_t;

  typedef struct packed {
    logic [RBW-1:0] row_bytes;
    logic [PLW-1:0] planes;
    logic [ROWW-1:0] rows;
    logic [PLW-1:0] slots;
    logic compressed;
  } cfg_t;

  typedef struct packed {
    logic [RBW-1:0] col;
    logic [PLW-1:0] plane;
    logic [ROWW-1:0] row;
  } pos_t;

  typedef struct packed {
    logic emit;
    pos_t pos;
    logic [RBW-1:0] start;
    logic [RUNW-1:0] n;
    logic done;
  } place_t;

endpackage

FILE: design/bbr_front.sv
module bbr_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] body_byte,
  output logic q_valid,
  output bbr_pkg::entry_t q_entry,
  input  logic q_pop
);

  bbr_pkg::entry_t slot [2];
  bbr_pkg::entry_t classified;
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;

  always_comb begin
    classified.body = body_byte;
    if (body_byte < 8'd128) begin
      classified.kind = bbr_pkg::KIND_LITERAL;
      classified.len = body_byte + 8'd1;
    end else if (body_byte > 8'd128) begin
      classified.kind = bbr_pkg::KIND_REPEAT;
      classified.len = 8'(9'd257 - {1'b0, body_byte});
    end else begin
      classified.kind = bbr_pkg::KIND_NOP;
      classified.len = '0;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign q_entry = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: design/bbr_back.sv
module bbr_back (
  input  logic clk,
  input  logic rst,
  input  bbr_pkg::cfg_t cfg,
  input  logic q_valid,
  input  bbr_pkg::entry_t q_entry,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] plane_index,
  output logic [11:0] row_index,
  output logic [9:0] column_start,
  output logic [7:0] data_byte,
  output logic [7:0] repeat_count,
  output logic image_done
);

  function automatic bbr_pkg::pos_t advance(input bbr_pkg::pos_t p, input bbr_pkg::cfg_t c);
    bbr_pkg::pos_t r;
    r = p;
    r.col = '0;
    r.plane = p.plane + 4'd1;
    if (r.plane >= c.slots) begin
      r.plane = '0;
      if (p.row < c.rows) begin
        r.row = p.row + 13'd1;
      end
    end
    return r;
  endfunction

  function automatic bbr_pkg::pos_t settle(input bbr_pkg::pos_t p, input bbr_pkg::cfg_t c);
    return (p.col >= c.row_bytes) ? advance(p, c) : p;
  endfunction

  function automatic bbr_pkg::place_t place(input bbr_pkg::pos_t p,
                                            input logic [bbr_pkg::RUNW-1:0] cnt,
                                            input bbr_pkg::cfg_t c);
    bbr_pkg::place_t r;
    logic [bbr_pkg::RBW-1:0] left;
    logic [bbr_pkg::RBW-1:0] n;
    logic room;
    left = c.row_bytes - p.col;
    n = ({3'b0, cnt} < left) ? {3'b0, cnt} : left;
    room = (p.col < c.row_bytes) && (n != '0);
    r.pos = p;
    r.start = p.col;
    r.n = n[bbr_pkg::RUNW-1:0];
    if (room) begin
      r.pos.col = p.col + n;
    end
    r.emit = room && (p.plane < c.planes);
    r.done = (p.plane + 4'd1 == c.planes) && (p.row + 13'd1 == c.rows)
             && (r.pos.col >= c.row_bytes);
    return r;
  endfunction

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [bbr_pkg::RUNW-1:0] run_left;
  logic [bbr_pkg::RUNW-1:0] run_left_next;
  bbr_pkg::pos_t pos;
  bbr_pkg::pos_t pos_next;
  bbr_pkg::pos_t pos_a;
  bbr_pkg::place_t pl;
  logic [bbr_pkg::RUNW-1:0] run_dec;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign q_pop = q_valid && out_free;

  always_comb begin
    phase_next = phase;
    run_left_next = run_left;
    pos_next = pos;
    pos_a = settle(pos, cfg);
    pl = '0;
    run_dec = (run_left != '0) ? run_left - 8'd1 : '0;
    if (!cfg.compressed) begin
      phase_next = bbr_pkg::PHASE_HEADER;
      run_left_next = '0;
      pos_next = pos_a;
      if (pos_a.row < cfg.rows) begin
        pl = place(pos_a, 8'd1, cfg);
        pos_next = settle(pl.pos, cfg);
      end
    end else begin
      unique case (phase)
        bbr_pkg::PHASE_LITERAL: begin
          if (pos.row < cfg.rows) begin
            pl = place(pos, 8'd1, cfg);
            run_left_next = run_dec;
            pos_next = pl.pos;
            if (run_dec == '0) begin
              phase_next = bbr_pkg::PHASE_HEADER;
              pos_next = settle(pl.pos, cfg);
            end
          end
        end
        bbr_pkg::PHASE_REPEAT: begin
          if (pos.row < cfg.rows) begin
            pl = place(pos, run_left, cfg);
            run_left_next = '0;
            phase_next = bbr_pkg::PHASE_HEADER;
            pos_next = settle(pl.pos, cfg);
          end
        end
        default: begin
          phase_next = bbr_pkg::PHASE_HEADER;
          pos_next = pos_a;
          if (pos_a.row < cfg.rows) begin
            unique case (q_entry.kind)
              bbr_pkg::KIND_LITERAL: begin
                run_left_next = q_entry.len;
                phase_next = bbr_pkg::PHASE_LITERAL;
              end
              bbr_pkg::KIND_REPEAT: begin
                run_left_next = q_entry.len;
                phase_next = bbr_pkg::PHASE_REPEAT;
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bbr_pkg::PHASE_HEADER;
      run_left <= '0;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        phase <= phase_next;
        run_left <= run_left_next;
        pos <= pos_next;
      end
      if (out_free) begin
        out_valid <= q_pop && pl.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && pl.emit) begin
      plane_index <= pl.pos.plane[2:0];
      row_index <= pl.pos.row[11:0];
      column_start <= pl.start[9:0];
      data_byte <= q_entry.body;
      repeat_count <= pl.n;
      image_done <= pl.done;
    end
  end

endmodule

FILE: design/bitplane_byterun1_decoder.sv
// Bitplane body decoder for ByteRun1 (PackBits) or raw image data. One body
// byte is taken per transaction and at most one run comes out per byte, as
// plane, row, column, value and a repeat count clipped to the row end. The
// block sustains one byte per clock while the output is not stalled. A taken
// byte waits in the input queue; the run decoder, whose position update sets
// the rate, turns it into a run on the registered outputs. A two-entry queue
// lets input and output stall independently. Write registers only while idle;
// a write reaches its register, then a registered clamped copy, before use.
module bitplane_byterun1_decoder #(
  parameter int MAX_ROW_BYTES = bbr_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_ROWS = bbr_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES = bbr_pkg::DEF_MAX_PLANES
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [bbr_pkg::CFG_IDXW-1:0] cfg_index,
  input  logic [bbr_pkg::CFG_DW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] body_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] plane_index,
  output logic [11:0] row_index,
  output logic [9:0] column_start,
  output logic [7:0] data_byte,
  output logic [7:0] repeat_count,
  output logic image_done
);

  function automatic logic [bbr_pkg::RBW-1:0] clamp_rb(input logic [bbr_pkg::RBW-1:0] v);
    return (v == '0) ? 11'd1 :
           (int'(v) > MAX_ROW_BYTES) ? bbr_pkg::RBW'(MAX_ROW_BYTES) : v;
  endfunction

  function automatic logic [bbr_pkg::PLW-1:0] clamp_pl(input logic [bbr_pkg::PLW-1:0] v);
    return (v == '0) ? 4'd1 :
           (int'(v) > MAX_PLANES) ? bbr_pkg::PLW'(MAX_PLANES) : v;
  endfunction

  function automatic logic [bbr_pkg::ROWW-1:0] clamp_rows(input logic [bbr_pkg::ROWW-1:0] v);
    return (int'(v) > MAX_ROWS) ? bbr_pkg::ROWW'(MAX_ROWS) : v;
  endfunction

  logic [bbr_pkg::RBW-1:0] row_bytes;
  logic [bbr_pkg::PLW-1:0] plane_count;
  logic [bbr_pkg::ROWW-1:0] image_rows;
  logic compressed;
  logic has_mask_plane;
  bbr_pkg::cfg_t eff;
  logic q_valid;
  logic q_pop;
  bbr_pkg::entry_t q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= bbr_pkg::RST_ROW_BYTES;
      plane_count <= bbr_pkg::RST_PLANE_COUNT;
      image_rows <= bbr_pkg::RST_IMAGE_ROWS;
      compressed <= bbr_pkg::RST_COMPRESSED;
      has_mask_plane <= bbr_pkg::RST_HAS_MASK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bbr_pkg::CFG_ROW_BYTES: row_bytes <= cfg_data[bbr_pkg::RBW-1:0];
        bbr_pkg::CFG_PLANE_COUNT: plane_count <= cfg_data[bbr_pkg::PLW-1:0];
        bbr_pkg::CFG_IMAGE_ROWS: image_rows <= cfg_data[bbr_pkg::ROWW-1:0];
        bbr_pkg::CFG_COMPRESSED: compressed <= cfg_data[0];
        bbr_pkg::CFG_HAS_MASK: has_mask_plane <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff.row_bytes <= clamp_rb(bbr_pkg::RST_ROW_BYTES);
      eff.planes <= clamp_pl(bbr_pkg::RST_PLANE_COUNT);
      eff.rows <= clamp_rows(bbr_pkg::RST_IMAGE_ROWS);
      eff.slots <= clamp_pl(bbr_pkg::RST_PLANE_COUNT) + {3'b0, bbr_pkg::RST_HAS_MASK};
      eff.compressed <= bbr_pkg::RST_COMPRESSED;
    end else begin
      eff.row_bytes <= clamp_rb(row_bytes);
      eff.planes <= clamp_pl(plane_count);
      eff.rows <= clamp_rows(image_rows);
      eff.slots <= clamp_pl(plane_count) + {3'b0, has_mask_plane};
      eff.compressed <= compressed;
    end
  end

  bbr_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .body_byte(body_byte),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .q_pop(q_pop)
  );

  bbr_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(eff),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .plane_index(plane_index),
    .row_index(row_index),
    .column_start(column_start),
    .data_byte(data_byte),
    .repeat_count(repeat_count),
    .image_done(image_done)
  );

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != 8'd0)
    else $error("run with zero length");

  a_run_in_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, column_start} + {3'b0, repeat_count}) <= eff.row_bytes)
    else $error("run crosses row end");

  a_image_plane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, plane_index} < eff.planes)
    else $error("run on mask plane");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |->
      ({1'b0, plane_index} + 4'd1 == eff.planes) && ({1'b0, row_index} + 13'd1 == eff.rows))
    else $error("done flag away from last plane row");

endmodule

FILE: tb/tb_bitplane_byterun1_decoder.sv
module tb_bitplane_byterun1_decoder;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [bbr_pkg::CFG_IDXW-1:0] cfg_index = '0;
  logic [bbr_pkg::CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] body_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] plane_index;
  logic [11:0] row_index;
  logic [9:0] column_start;
  logic [7:0] data_byte;
  logic [7:0] repeat_count;
  logic image_done;

  bitplane_byterun1_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .body_byte(body_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .plane_index(plane_index),
    .row_index(row_index),
    .column_start(column_start),
    .data_byte(data_byte),
    .repeat_count(repeat_count),
    .image_done(image_done)
  );

  typedef struct {
    logic [2:0] plane;
    logic [11:0] row;
    logic [9:0] col;
    logic [7:0] value;
    logic [7:0] count;
    logic done;
  } run_t;

  // decoder shadow: registers and position
  logic [bbr_pkg::RBW-1:0] reg_row_bytes;
  logic [bbr_pkg::PLW-1:0] reg_planes;
  logic [bbr_pkg::ROWW-1:0] reg_rows;
  logic reg_compressed;
  logic reg_mask;
  logic [1:0] code_phase;
  int unsigned run_left;
  int unsigned col_pos;
  int unsigned plane_pos;
  int unsigned row_pos;

  run_t expected_runs[$];
  logic [7:0] pending_bytes[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_div = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit byte_taken = 1'b0;

  function automatic int unsigned row_len();
    int unsigned r;
    r = reg_row_bytes;
    if (r < 1) r = 1;
    if (r > bbr_pkg::DEF_MAX_ROW_BYTES) r = bbr_pkg::DEF_MAX_ROW_BYTES;
    return r;
  endfunction

  function automatic int unsigned plane_total();
    int unsigned p;
    p = reg_planes;
    if (p < 1) p = 1;
    if (p > bbr_pkg::DEF_MAX_PLANES) p = bbr_pkg::DEF_MAX_PLANES;
    return p;
  endfunction

  function automatic int unsigned row_total();
    int unsigned r;
    r = reg_rows;
    if (r > bbr_pkg::DEF_MAX_ROWS) r = bbr_pkg::DEF_MAX_ROWS;
    return r;
  endfunction

  task automatic next_row_slot();
    int unsigned slots;
    slots = plane_total() + (reg_mask ? 1 : 0);
    col_pos = 0;
    plane_pos++;
    if (plane_pos >= slots) begin
      plane_pos = 0;
      if (row_pos < row_total()) row_pos++;
    end
  endtask

  task automatic place_bytes(input logic [7:0] value, input int unsigned count);
    int unsigned rb;
    int unsigned n;
    int unsigned start_col;
    run_t r;
    rb = row_len();
    if (col_pos >= rb) return;
    n = (count < rb - col_pos) ? count : rb - col_pos;
    if (n == 0) return;
    start_col = col_pos;
    col_pos += n;
    if (plane_pos >= plane_total()) return;
    r.plane = plane_pos[2:0];
    r.row = row_pos[11:0];
    r.col = start_col[9:0];
    r.value = value;
    r.count = n[7:0];
    r.done = (plane_pos + 1 == plane_total()) && (row_pos + 1 == row_total()) &&
             (col_pos >= rb);
    expected_runs.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int unsigned rb;
    rb = row_len();
    if (!reg_compressed) begin
      code_phase = bbr_pkg::PHASE_HEADER;
      run_left = 0;
      if (col_pos >= rb) next_row_slot();
      if (row_pos >= row_total()) return;
      place_bytes(b, 1);
      if (col_pos >= rb) next_row_slot();
    end else if (code_phase == bbr_pkg::PHASE_LITERAL) begin
      if (row_pos >= row_total()) return;
      place_bytes(b, 1);
      if (run_left > 0) run_left--;
      if (run_left == 0) begin
        code_phase = bbr_pkg::PHASE_HEADER;
        if (col_pos >= rb) next_row_slot();
      end
    end else if (code_phase == bbr_pkg::PHASE_REPEAT) begin
      if (row_pos >= row_total()) return;
      place_bytes(b, run_left);
      run_left = 0;
      code_phase = bbr_pkg::PHASE_HEADER;
      if (col_pos >= rb) next_row_slot();
    end else begin
      if (col_pos >= rb) next_row_slot();
      if (row_pos >= row_total()) return;
      if (b < 128) begin
        run_left = b + 1;
        code_phase = bbr_pkg::PHASE_LITERAL;
      end else if (b > 128) begin
        run_left = 257 - b;
        code_phase = bbr_pkg::PHASE_REPEAT;
      end
    end
  endtask

  task automatic write_reg(input logic [bbr_pkg::CFG_IDXW-1:0] idx, input int unsigned value);
    logic [bbr_pkg::CFG_DW-1:0] data;
    data = bbr_pkg::CFG_DW'($urandom);
    case (idx)
      bbr_pkg::CFG_ROW_BYTES: begin
        data[bbr_pkg::RBW-1:0] = value[bbr_pkg::RBW-1:0];
        reg_row_bytes = data[bbr_pkg::RBW-1:0];
      end
      bbr_pkg::CFG_PLANE_COUNT: begin
        data[bbr_pkg::PLW-1:0] = value[bbr_pkg::PLW-1:0];
        reg_planes = data[bbr_pkg::PLW-1:0];
      end
      bbr_pkg::CFG_IMAGE_ROWS: begin
        data[bbr_pkg::ROWW-1:0] = value[bbr_pkg::ROWW-1:0];
        reg_rows = data[bbr_pkg::ROWW-1:0];
      end
      bbr_pkg::CFG_COMPRESSED: begin
        data[0] = value[0];
        reg_compressed = data[0];
      end
      bbr_pkg::CFG_HAS_MASK: begin
        data[0] = value[0];
        reg_mask = data[0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic program_regs(input int unsigned rb, input int unsigned pc,
                              input int unsigned rows, input int unsigned comp,
                              input int unsigned mask);
    write_reg(bbr_pkg::CFG_ROW_BYTES, rb);
    write_reg(bbr_pkg::CFG_PLANE_COUNT, pc);
    write_reg(bbr_pkg::CFG_IMAGE_ROWS, rows);
    write_reg(bbr_pkg::CFG_COMPRESSED, comp);
    write_reg(bbr_pkg::CFG_HAS_MASK, mask);
    @(negedge clk);
    cfg_write <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endtask

  task automatic gen_raw(input int unsigned n_items);
    int unsigned k;
    for (k = 0; k < n_items; k++) push_byte(8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed packets; end on an open run so the next setting sees it
  task automatic gen_coded(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 15);
      if (pick < 7) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
        push_byte(8'(len - 1));
        for (k = 0; k < len; k++) push_byte(8'($urandom_range(0, 255)));
        sent += len + 1;
      end else if (pick < 13) begin
        if ($urandom_range(0, 1) == 1) push_byte(8'($urandom_range(129, 255)));
        else push_byte(8'($urandom_range(240, 255)));
        push_byte(8'($urandom_range(0, 255)));
        sent += 2;
      end else if (pick == 13) begin
        push_byte(8'd128);
        sent++;
      end else begin
        push_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      push_byte(8'($urandom_range(4, 40)));
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_byte(8'($urandom_range(129, 255)));
    end
  endtask

  task automatic drain();
    while (accepted_total != queued_total || expected_runs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !byte_taken)) begin
      byte_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_div != 0 && $urandom_range(1, idle_div) == 1) begin
        gap_left = $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        body_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_div != 0 && $urandom_range(1, idle_div) == 1) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check results, then record accepted bytes
  always @(posedge clk) begin : monitor
    run_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected run: plane_index %0d row_index %0d column_start %0d",
                 plane_index, row_index, column_start);
          mismatches++;
        end else begin
          want = expected_runs.pop_front();
          if (plane_index !== want.plane) begin
            $error("plane_index expected %0d actual %0d", want.plane, plane_index);
            mismatches++;
          end
          if (row_index !== want.row) begin
            $error("row_index expected %0d actual %0d", want.row, row_index);
            mismatches++;
          end
          if (column_start !== want.col) begin
            $error("column_start expected %0d actual %0d", want.col, column_start);
            mismatches++;
          end
          if (data_byte !== want.value) begin
            $error("data_byte expected %0d actual %0d", want.value, data_byte);
            mismatches++;
          end
          if (repeat_count !== want.count) begin
            $error("repeat_count expected %0d actual %0d", want.count, repeat_count);
            mismatches++;
          end
          if (image_done !== want.done) begin
            $error("image_done expected %0d actual %0d", want.done, image_done);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(body_byte);
        accepted_total++;
        byte_taken = 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] opening_bytes[$];
    int unsigned ph;
    opening_bytes = '{8'h80, 8'h00, 8'hFF, 8'h04, 8'h00, 8'h01, 8'h7F,
                      8'h80, 8'hFE, 8'hFF, 8'h55, 8'h81, 8'hAA, 8'hFE,
                      8'h00, 8'h01, 8'hC3, 8'h3C};
    reg_row_bytes = bbr_pkg::RST_ROW_BYTES;
    reg_planes = bbr_pkg::RST_PLANE_COUNT;
    reg_rows = bbr_pkg::RST_IMAGE_ROWS;
    reg_compressed = bbr_pkg::RST_COMPRESSED;
    reg_mask = bbr_pkg::RST_HAS_MASK;
    code_phase = bbr_pkg::PHASE_HEADER;
    run_left = 0;
    col_pos = 0;
    plane_pos = 0;
    row_pos = 0;
    while (rst) @(negedge clk);

    // short rows: no-op header, literals spilling past row end, clipped repeats
    program_regs(3, 2, 4096, 1, 0);
    foreach (opening_bytes[i]) push_byte(opening_bytes[i]);
    drain();

    idle_div = 4;
    program_regs(1, 1, 8191, 1, 1);
    gen_coded(120);
    drain();

    idle_div = 8;
    program_regs(1024, 8, 4096, 1, 0);
    gen_coded(150);
    drain();

    idle_div = 3;
    program_regs(2047, 15, 4096, 0, 0);
    gen_raw(100);
    drain();

    idle_div = 0;
    program_regs(0, 0, 4096, 0, 1);
    gen_raw(100);
    drain();

    // finish the image, then keep feeding bytes that must be dropped
    idle_div = 6;
    program_regs(5, 3, row_pos + 1, 0, 1);
    gen_raw(40);
    drain();

    program_regs(5, 3, row_pos + 1, 1, 1);
    gen_coded(120);
    drain();

    program_regs(4, 2, 0, 1, 0);
    gen_coded(30);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: idle_div = 3;
        1: idle_div = 12;
        2: idle_div = 0;
        default: idle_div = 6;
      endcase
      if (ph == 5) idle_div = 0;
      program_regs($urandom_range(1, 16), $urandom_range(1, 8), row_pos + $urandom_range(2, 30),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      if (reg_compressed) gen_coded(110);
      else gen_raw(110);
      drain();
    end

    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
